// File: src/fragment_priority_table_unit_assert.svh
// Assertion macros for the fragment priority table RTL.
`ifndef FRAGMENT_PRIORITY_TABLE_UNIT_ASSERT_SVH
`define FRAGMENT_PRIORITY_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define FPT_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define FPT_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`define FPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define FPT_ASSERT(lbl, clk, rst_n, cond, msg)
`define FPT_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define FPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// File: src/fpt_pkg.sv
// Types and constants of the fragment priority table.
`default_nettype none

package fpt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned PRIO_W   = 2;
  localparam int unsigned LIFE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam int unsigned CFG_PADDR_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register index, taken from paddr above the byte offset.
  localparam logic REG_ENTRY_LIFETIME = 1'b0;

  localparam logic [LIFE_W-1:0] LIFETIME_RST = 8'd6;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [PRIO_W-1:0] PRIORITY_LOW    = 2'd0;
  localparam logic [PRIO_W-1:0] PRIORITY_NORMAL = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_ENTRY = 2'd1,
    ST_HDR_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [LIFE_W-1:0] ticks;
  } entry_t;

  typedef struct packed {
    logic              op;
    logic              frag;
    logic [ADDR_W-1:0] src;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] flen;
    logic [SIZE_W-1:0] dsize;
    logic [PRIO_W-1:0] hprio;
    logic              hok;
  } item_t;

endpackage

`default_nettype wire

// File: src/fragment_priority_table_unit.sv
// Fragment priority table: per-datagram forwarding priority and lifetime tracking.
//
// Input channel (in_*): one word per frame or time tick; tuser carries the kind
// of word, tdata the frame and fragment header fields. Output channel (out_*):
// one word per input word with the forwarding priority, a status code and a
// flag that tells whether any table entry is still live.
// Config port (cfg_*): APB style, one register, entry_lifetime at address 0.
//
// Every word walks the whole table once through the read port of the entry
// memory, one entry per cycle; a tick writes back each live entry as it is
// checked, and a frame word then applies at most one write. The block takes
// the next word only after the previous one has passed the scan, apply and
// done states and its result is registered.
// A new word is accepted while the previous result still waits in the output
// register; if the receiver stalls longer, the block holds before writing its
// next result and takes no further word.
// Reset clears all entry valid bits at once and loads entry_lifetime with 6;
// the block accepts words in the cycle after reset.
`default_nettype none

`include "fragment_priority_table_unit_assert.svh"

module fragment_priority_table_unit
  import fpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // src_addr[15:0], datagram_tag[31:16], datagram_offset[42:32],
  // fragment_length[53:43], datagram_size[64:54], header_priority[66:65],
  // header_priority_ok[67], zero fill[71:68]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[0], is_fragment[1]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // priority_res[1:0], status[3:2], table_nonempty[4], zero fill[7:5]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_PADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_t;

  // Configuration register.
  logic [LIFE_W-1:0] lifetime_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_PADDR_W-1] == REG_ENTRY_LIFETIME);
  assign cfg_prdata = (cfg_paddr[CFG_PADDR_W-1] == REG_ENTRY_LIFETIME) ?
                      {{(CFG_DATA_W-LIFE_W){1'b0}}, lifetime_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RST;
    end else if (cfg_wr) begin
      lifetime_r <= cfg_pwdata[LIFE_W-1:0];
    end
  end

  // Control state.
  state_t                   state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     rd_busy_r, rd_busy_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic                     hit_found_r, hit_found_nxt;
  logic                     free_found_r, free_found_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;

  // Payload state.
  item_t                    item_r, item_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic [PRIO_W-1:0]        hit_prio_r, hit_prio_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [PRIO_W-1:0]        res_prio_r, res_prio_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  // Entry memory.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wentry;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  fpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign ram_re    = (state_r == S_SCAN) && rd_busy_r;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  logic              pend_valid;
  logic              pend_match;
  logic [LIFE_W-1:0] ticks_dec;
  logic              is_last;
  logic              is_later;
  logic              create;

  assign pend_valid = valid_r[pend_idx_r];
  assign pend_match = pend_valid && (rd_entry.source == item_r.src) &&
                      (rd_entry.tag == item_r.tag);
  assign ticks_dec  = (rd_entry.ticks != '0) ? rd_entry.ticks - 1'b1 : '0;
  // Offset plus length may exceed 11 bits, so the compare is one bit wider.
  assign is_last    = ({1'b0, item_r.offset} + {1'b0, item_r.flen}) >=
                      {1'b0, item_r.dsize};
  assign is_later   = item_r.frag && (item_r.offset != '0);
  assign create     = (state_r == S_APPLY) && (item_r.op == OP_FRAME) &&
                      !is_later && item_r.hok && item_r.frag &&
                      !hit_found_r && free_found_r;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    rd_busy_nxt    = rd_busy_r;
    pend_vld_nxt   = 1'b0;
    pend_idx_nxt   = rd_idx_r;
    hit_found_nxt  = hit_found_r;
    free_found_nxt = free_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_prio_nxt   = hit_prio_r;
    free_idx_nxt   = free_idx_r;
    item_nxt       = item_r;
    res_prio_nxt   = res_prio_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_idx_r;
    ram_wentry     = '{source: rd_entry.source, tag: rd_entry.tag,
                       prio: rd_entry.prio, ticks: ticks_dec};

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt = '{op: in_tuser[0], frag: in_tuser[1],
                       src: in_tdata[15:0], tag: in_tdata[31:16],
                       offset: in_tdata[42:32], flen: in_tdata[53:43],
                       dsize: in_tdata[64:54], hprio: in_tdata[66:65],
                       hok: in_tdata[67]};
          rd_idx_nxt     = '0;
          rd_busy_nxt    = 1'b1;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Reads run one entry ahead of the data being checked; a tick writes
        // back the entry behind the read address, so the two never collide.
        pend_vld_nxt = rd_busy_r;
        if (rd_busy_r) begin
          if (rd_idx_r == LAST_IDX) begin
            rd_busy_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (pend_vld_r) begin
          if (item_r.op == OP_TICK) begin
            if (pend_valid) begin
              ram_we = 1'b1;
              if (ticks_dec == '0) begin
                valid_nxt[pend_idx_r] = 1'b0;
                cnt_nxt               = cnt_nxt - 1'b1;
              end
            end
          end else begin
            if (pend_match && !hit_found_r) begin
              hit_found_nxt = 1'b1;
              hit_idx_nxt   = pend_idx_r;
              hit_prio_nxt  = rd_entry.prio;
            end
            if (!pend_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = pend_idx_r;
            end
          end
          if (pend_idx_r == LAST_IDX) begin
            state_nxt = S_APPLY;
          end
        end
      end

      S_APPLY: begin
        ram_waddr  = hit_idx_r;
        ram_wentry = '{source: item_r.src, tag: item_r.tag,
                       prio: hit_prio_r, ticks: lifetime_r};
        res_prio_nxt   = PRIORITY_LOW;
        res_status_nxt = ST_OK;
        if (item_r.op == OP_FRAME) begin
          if (is_later && !hit_found_r) begin
            res_prio_nxt   = PRIORITY_NORMAL;
            res_status_nxt = ST_NO_ENTRY;
          end else if (is_later || item_r.hok) begin
            res_prio_nxt = is_later ? hit_prio_r : item_r.hprio;
            if (item_r.frag) begin
              if (hit_found_r) begin
                // A matched fragment ends its datagram or keeps it alive.
                if (is_last) begin
                  valid_nxt[hit_idx_r] = 1'b0;
                  cnt_nxt              = cnt_r - 1'b1;
                end else begin
                  ram_we = 1'b1;
                end
              end else if (free_found_r) begin
                ram_we               = 1'b1;
                ram_waddr            = free_idx_r;
                ram_wentry.prio      = item_r.hprio;
                valid_nxt[free_idx_r] = 1'b1;
                cnt_nxt              = cnt_r + 1'b1;
              end
            end
          end else begin
            res_prio_nxt   = PRIORITY_NORMAL;
            res_status_nxt = ST_HDR_FAIL;
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_TDATA_W-5){1'b0}}, (cnt_r != '0),
                            res_status_r, res_prio_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_prio_r   <= hit_prio_nxt;
    free_idx_r   <= free_idx_nxt;
    res_prio_r   <= res_prio_nxt;
    res_status_r <= res_status_nxt;
    out_tdata_r  <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      rd_busy_r    <= 1'b0;
      pend_vld_r   <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_busy_r    <= rd_busy_nxt;
      pend_vld_r   <= pend_vld_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // The live-entry count must track the valid bits exactly.
  `FPT_ASSERT(a_cnt_matches_valid, clk, rst_n, $countones(valid_r) == cnt_r,
    "entry count differs from valid bits")

  // A frame scan only reads; writes then would corrupt entries not yet checked.
  `FPT_ASSERT_IMPLY(a_no_write_frame_scan, clk, rst_n,
    (state_r == S_SCAN) && (item_r.op == OP_FRAME), !ram_we,
    "memory written during a frame scan")

  // A new entry must land in a slot that was free.
  `FPT_ASSERT_IMPLY(a_create_in_free_slot, clk, rst_n, create,
    !valid_r[free_idx_r] && ram_we && (ram_waddr == free_idx_r),
    "entry created over a live slot")

  // A result word is loaded only on the way back to idle.
  `FPT_ASSERT_NEXT(a_result_then_idle, clk, rst_n,
    (state_r == S_DONE) && (!out_tvalid_r || out_tready),
    out_tvalid_r && (state_r == S_IDLE),
    "result not presented after completion")

endmodule

`default_nettype wire

// File: src/fpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the fragment priority table: directed and random frames and ticks vs. a table model.
`timescale 1ns / 100ps

module tb_top;
  import fpt_pkg::*;

  localparam int ENTRIES = TABLE_ENTRIES_DEF;
  localparam logic [CFG_PADDR_W-1:0] LIFETIME_ADDR = CFG_PADDR_W'({REG_ENTRY_LIFETIME, 2'b00});

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    status_t           status;
    logic              nonempty;
  } verdict_t;

  typedef struct {
    logic [ADDR_W-1:0] src;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W:0]   next_off;
    logic [SIZE_W-1:0] dsize;
  } dgram_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_PADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  fragment_priority_table_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Model of the table, updated as each word is accepted.
  logic [ENTRIES-1:0] live = '0;
  logic [ADDR_W-1:0]  src_tab   [ENTRIES];
  logic [TAG_W-1:0]   tag_tab   [ENTRIES];
  logic [PRIO_W-1:0]  prio_tab  [ENTRIES];
  logic [LIFE_W-1:0]  ticks_tab [ENTRIES];
  logic [LIFE_W-1:0]  lifetime_cfg = LIFETIME_RST;

  item_t    pending_words[$];
  verdict_t expected_verdicts[$];
  dgram_t   active_dgrams[$];
  item_t    cur_word;
  int       results_seen = 0;
  int       mismatches = 0;

  // Both sides stop idling for a long stretch in the middle of the run.
  wire calm = (results_seen >= 450) && (results_seen < 650);

  function automatic int find_entry(logic [ADDR_W-1:0] src, logic [TAG_W-1:0] tag);
    int hit;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && live[i] && src_tab[i] == src && tag_tab[i] == tag) hit = i;
    return hit;
  endfunction

  function automatic verdict_t table_step(item_t w);
    verdict_t v;
    int hit;
    int slot;
    logic touch;
    logic [SIZE_W:0] reach;
    v.prio = PRIORITY_LOW;
    v.status = ST_OK;
    hit = -1;
    slot = -1;
    touch = 1'b0;
    if (w.op == OP_TICK) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (live[i]) begin
          if (ticks_tab[i] != 0) ticks_tab[i] = ticks_tab[i] - 1'b1;
          if (ticks_tab[i] == 0) live[i] = 1'b0;
        end
      end
    end else begin
      if (w.frag && w.offset != 0) begin
        hit = find_entry(w.src, w.tag);
        if (hit < 0) begin
          v.prio = PRIORITY_NORMAL;
          v.status = ST_NO_ENTRY;
        end else begin
          v.prio = prio_tab[hit];
          touch = 1'b1;
        end
      end else if (w.hok) begin
        v.prio = w.hprio;
        touch = w.frag;
      end else begin
        v.prio = PRIORITY_NORMAL;
        v.status = ST_HDR_FAIL;
      end
      if (touch) begin
        if (hit < 0) hit = find_entry(w.src, w.tag);
        reach = w.offset + w.flen;
        if (hit < 0) begin
          if (w.offset == 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot < 0 && !live[i]) slot = i;
            if (slot >= 0) begin
              live[slot] = 1'b1;
              src_tab[slot] = w.src;
              tag_tab[slot] = w.tag;
              prio_tab[slot] = v.prio;
              ticks_tab[slot] = lifetime_cfg;
            end
          end
        end else if (reach >= w.dsize) begin
          live[hit] = 1'b0;
        end else begin
          ticks_tab[hit] = lifetime_cfg;
        end
      end
    end
    v.nonempty = |live;
    return v;
  endfunction

  // Driver: presents queued words; the model advances on each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_verdicts.push_back(table_step(cur_word));
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
          cur_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'({cur_word.hok, cur_word.hprio, cur_word.dsize,
                                   cur_word.flen, cur_word.offset, cur_word.tag,
                                   cur_word.src});
          in_tuser <= {cur_word.frag, cur_word.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          mismatches++;
        end else begin
          verdict_t v;
          v = expected_verdicts.pop_front();
          if (out_tdata[1:0] !== v.prio) begin
            $error("priority_res: expected %0d, got %0d", v.prio, out_tdata[1:0]);
            mismatches++;
          end
          if (out_tdata[3:2] !== v.status) begin
            $error("status: expected %0d, got %0d", v.status, out_tdata[3:2]);
            mismatches++;
          end
          if (out_tdata[4] !== v.nonempty) begin
            $error("table_nonempty: expected %0d, got %0d", v.nonempty, out_tdata[4]);
            mismatches++;
          end
          if (out_tdata[7:5] !== 3'b000) begin
            $error("zero fill: expected 0, got %0d", out_tdata[7:5]);
            mismatches++;
          end
        end
        results_seen++;
      end
      out_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  function automatic item_t mk_word(logic op, logic frag, logic [ADDR_W-1:0] src,
                                    logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] offset,
                                    logic [SIZE_W-1:0] flen, logic [SIZE_W-1:0] dsize,
                                    logic [PRIO_W-1:0] hprio, logic hok);
    item_t w;
    w.op = op;
    w.frag = frag;
    w.src = src;
    w.tag = tag;
    w.offset = offset;
    w.flen = flen;
    w.dsize = dsize;
    w.hprio = hprio;
    w.hok = hok;
    return w;
  endfunction

  task automatic start_dgram(input bit sure_hok);
    dgram_t d;
    item_t w;
    logic [SIZE_W-1:0] flen;
    case ($urandom_range(0, 5))
      0: d.src = 16'h0000;
      1: d.src = 16'hFFFF;
      2: d.src = 16'h00A5;
      3: d.src = 16'h5A00;
      4: d.src = 16'h1234;
      default: d.src = 16'h7C31;
    endcase
    d.tag = ($urandom_range(99) < 60) ? TAG_W'($urandom_range(0, 3)) : TAG_W'($urandom);
    d.dsize = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(1024, 2047))
                                       : SIZE_W'($urandom_range(16, 600));
    flen = ($urandom_range(99) < 4) ? '0 : SIZE_W'($urandom_range(1, 300));
    w = mk_word(OP_FRAME, 1'b1, d.src, d.tag, '0, flen, d.dsize, PRIO_W'($urandom),
                sure_hok || ($urandom_range(99) < 92));
    pending_words.push_back(w);
    d.next_off = {1'b0, flen};
    if (flen < d.dsize) active_dgrams.push_back(d);
  endtask

  task automatic next_fragment();
    int idx;
    int left;
    int r;
    dgram_t d;
    logic [SIZE_W-1:0] flen;
    logic [SIZE_W-1:0] off;
    idx = $urandom_range(0, active_dgrams.size() - 1);
    d = active_dgrams[idx];
    left = int'(d.dsize) - int'(d.next_off);
    r = $urandom_range(99);
    if (r < 25) flen = SIZE_W'(left);
    else if (r < 35) flen = SIZE_W'($urandom_range(left, 2047));
    else flen = SIZE_W'($urandom_range(1, left));
    off = d.next_off[SIZE_W-1:0];
    // Now and then a fragment arrives with a bogus offset.
    if ($urandom_range(99) < 4) off = SIZE_W'($urandom);
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, d.src, d.tag, off, flen, d.dsize,
                                    PRIO_W'($urandom), 1'($urandom)));
    d.next_off = d.next_off + flen;
    if (d.next_off >= d.dsize || $urandom_range(99) < 3) active_dgrams.delete(idx);
    else active_dgrams[idx] = d;
  endtask

  task automatic queue_random(input int n);
    int r;
    logic [95:0] bits;
    item_t w;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      bits = {$urandom, $urandom, $urandom};
      w = bits[$bits(item_t)-1:0];
      if (r < 12) begin
        w.op = OP_TICK;
        pending_words.push_back(w);
      end else if (r < 18) begin
        w.op = OP_FRAME;
        pending_words.push_back(w);
      end else if (r < 26) begin
        w.op = OP_FRAME;
        w.frag = 1'b0;
        w.hok = ($urandom_range(99) < 85);
        pending_words.push_back(w);
      end else if (active_dgrams.size() == 0 || (active_dgrams.size() < 20 && r < 48)) begin
        start_dgram(1'b0);
      end else begin
        next_fragment();
      end
    end
  endtask

  // Returns once every queued word has been taken and every result has come back.
  task automatic settle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [LIFE_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= LIFETIME_ADDR;
    cfg_pwdata <= {CFG_DATA_W'($urandom) >> LIFE_W << LIFE_W} | CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    lifetime_cfg = value;
  endtask

  task automatic read_lifetime();
    logic [CFG_DATA_W-1:0] got;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= LIFETIME_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== CFG_DATA_W'(lifetime_cfg)) begin
      $error("entry_lifetime: expected %0d, got %0d", lifetime_cfg, got);
      mismatches++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_lifetime();

    // Directed words with the reset lifetime of six ticks.
    pending_words.push_back(mk_word(OP_TICK, 1'b1, '1, '1, '1, '1, '1, 2'd3, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b0, '1, '1, '1, '1, '1, 2'd3, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b0, '0, '0, '0, '0, '0, 2'd0, 1'b0));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd1, 16'd1, '0, 11'd8, 11'd64, 2'd2, 1'b0));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '1, '1, '1, '1, '1, 2'd2, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '0, '0, '0, 11'd40, 11'd100, 2'd2, 1'b1));
    // A repeated first fragment reports its own header priority but keeps the stored one.
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '0, '0, '0, 11'd40, 11'd100, 2'd0, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '0, '0, 11'd40, 11'd40, 11'd100, 2'd0, 1'b0));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '0, '0, 11'd80, 11'd20, 11'd100, 2'd0, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '0, '0, 11'd100, 11'd5, 11'd100, 2'd3, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '1, '1, '0, '0, '1, 2'd3, 1'b1));
    // The last-fragment sum must not wrap at eleven bits.
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, '1, '1, '1, '1, '1, 2'd0, 1'b0));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd5, 16'd9, '0, 11'd10, 11'd10, 2'd1, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd5, 16'd9, '0, 11'd10, 11'd10, 2'd3, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd7, 16'd7, '0, 11'd8, 11'd64, 2'd0, 1'b1));
    repeat (6) pending_words.push_back(mk_word(OP_TICK, 1'b0, '0, '0, '0, '0, '0, 2'd0, 1'b0));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd7, 16'd7, 11'd8, 11'd8, 11'd64, 2'd0, 1'b1));
    settle();

    write_lifetime(8'd1);
    read_lifetime();
    queue_random(260);
    settle();

    // Long lifetimes with a burst of new datagrams so that the table fills up.
    write_lifetime(8'd255);
    read_lifetime();
    repeat (18) start_dgram(1'b1);
    queue_random(240);
    settle();

    // With a zero lifetime a new entry lives only until the next tick.
    write_lifetime(8'd0);
    read_lifetime();
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd2, 16'd3, '0, 11'd4, 11'd50, 2'd2, 1'b1));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd2, 16'd3, 11'd4, 11'd4, 11'd50, 2'd0, 1'b1));
    pending_words.push_back(mk_word(OP_TICK, 1'b0, '0, '0, '0, '0, '0, 2'd0, 1'b0));
    pending_words.push_back(mk_word(OP_FRAME, 1'b1, 16'd2, 16'd3, 11'd8, 11'd4, 11'd50, 2'd0, 1'b1));
    queue_random(100);
    settle();

    write_lifetime(8'd3);
    read_lifetime();
    queue_random(250);
    settle();

    write_lifetime(LIFE_W'($urandom_range(1, 255)));
    read_lifetime();
    queue_random(190);
    settle();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/fpt_pkg.sv
src/fpt_ram.sv
src/fragment_priority_table_unit.sv
bench/tb_top.sv
